@@ design/sasa_pkg.sv @@
package sasa_pkg;

	localparam int unsigned DIM_W    = 12;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned COLOR_W  = 32;
	localparam int unsigned PACKED_W = 13;
	localparam int unsigned LOG2_W   = 4;
	localparam int unsigned MIN_LOG2 = 6;
	localparam int unsigned PAD      = 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	typedef logic [1:0] status_t;

	localparam status_t ST_PLACED   = 2'd0;
	localparam status_t ST_SKIPPED  = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	localparam logic CFG_ATLAS_W = 1'b0;
	localparam logic CFG_ATLAS_H = 1'b1;

	// round(c * a / 255) as (c * a + 127) / 255; n < 2^16 so the shift form is exact
	function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
			input logic [CHAN_W-1:0] a);
		logic [2*CHAN_W-1:0] n;
		logic [2*CHAN_W:0]   s;
		begin
			n = c * a + 16'd127;
			s = {1'b0, n} + 17'd1 + {9'd0, n[2*CHAN_W-1:CHAN_W]};
			premul = s[2*CHAN_W-1:CHAN_W];
		end
	endfunction

endpackage

@@ design/shelf_atlas_slot_allocator_core.sv @@
// Shelf atlas slot allocator. One glyph rectangle per transfer is placed on horizontal
// shelves of a 2^W x 2^H atlas (exponents clamped to 6..MAX_ATLAS_LOG2) with a one-pixel
// pad ring; each input transfer yields exactly one result transfer. An item enters an input
// register, is placed by one pass of add/compare logic against the shelf cursor, and lands
// in the result register; a new item is taken every cycle unless in_stall is high, since
// the cursor update closes within that single pass. in_stall rises only while both the input
// and the result registers hold items and out_stall is high. Overflow is sticky until an item
// with first_of_frame set. Write the atlas size registers only while the block is empty.
module shelf_atlas_slot_allocator_core #(
	parameter int unsigned MAX_ATLAS_LOG2 = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [sasa_pkg::LOG2_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          first_of_frame,
	input  logic [sasa_pkg::DIM_W-1:0]    glyph_width,
	input  logic [sasa_pkg::DIM_W-1:0]    glyph_height,
	input  logic [sasa_pkg::COLOR_W-1:0]  glyph_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sasa_pkg::status_t             status,
	output logic [sasa_pkg::DIM_W-1:0]    slot_x,
	output logic [sasa_pkg::DIM_W-1:0]    slot_y,
	output logic [sasa_pkg::FRAC_W-1:0]   u_start,
	output logic [sasa_pkg::FRAC_W-1:0]   v_start,
	output logic [sasa_pkg::FRAC_W-1:0]   u_end,
	output logic [sasa_pkg::FRAC_W-1:0]   v_end,
	output logic [sasa_pkg::CHAN_W-1:0]   red,
	output logic [sasa_pkg::CHAN_W-1:0]   green,
	output logic [sasa_pkg::CHAN_W-1:0]   blue,
	output logic [sasa_pkg::CHAN_W-1:0]   alpha,
	output logic [sasa_pkg::PACKED_W-1:0] packed_height
);

	localparam int unsigned PW = MAX_ATLAS_LOG2 + 1;
	localparam int unsigned SW = ((MAX_ATLAS_LOG2 > sasa_pkg::DIM_W) ?
		MAX_ATLAS_LOG2 : sasa_pkg::DIM_W) + 2;
	localparam int unsigned FW = SW + sasa_pkg::FRAC_W;
	localparam logic [sasa_pkg::LOG2_W-1:0] LOG2_HI = sasa_pkg::LOG2_W'(MAX_ATLAS_LOG2);
	localparam logic [sasa_pkg::LOG2_W-1:0] LOG2_LO = sasa_pkg::LOG2_W'(sasa_pkg::MIN_LOG2);

	logic [sasa_pkg::LOG2_W-1:0] atlas_w_log2_q, atlas_h_log2_q;

	logic [PW-1:0] cursor_x_q, cursor_y_q, shelf_h_q;
	logic          overflow_q;

	logic                         valid_s1;
	logic                         first_s1;
	logic [sasa_pkg::DIM_W-1:0]   w_s1, h_s1;
	logic [sasa_pkg::COLOR_W-1:0] color_s1;

	logic advance;
	logic take_in;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_log2_q <= sasa_pkg::LOG2_W'(8);
			atlas_h_log2_q <= sasa_pkg::LOG2_W'(8);
		end else if (cfg_write) begin
			case (cfg_index)
				sasa_pkg::CFG_ATLAS_W: atlas_w_log2_q <= cfg_data;
				sasa_pkg::CFG_ATLAS_H: atlas_h_log2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			first_s1 <= first_of_frame;
			w_s1     <= glyph_width;
			h_s1     <= glyph_height;
			color_s1 <= glyph_color;
		end
	end

	logic [sasa_pkg::LOG2_W-1:0] lw, lh;
	logic [SW-1:0] aw, ah;
	logic [SW-1:0] x0, y0, row0;
	logic          ovf0;
	logic [SW-1:0] w_ext, h_ext;
	logic          brk, fit, zero_sz, place;
	logic [SW-1:0] x1, y1, row1;
	logic [SW-1:0] x_end, y_end, h_pad;
	logic [SW-1:0] nx, ny, nrow;
	logic          novf;
	logic [SW-1:0] packed_sum;
	logic [FW-1:0] fx0, fy0, fx1, fy1;
	logic [sasa_pkg::CHAN_W-1:0] a_c;
	sasa_pkg::status_t st_c;

	always_comb begin
		lw = (atlas_w_log2_q < LOG2_LO) ? LOG2_LO :
			(atlas_w_log2_q > LOG2_HI) ? LOG2_HI : atlas_w_log2_q;
		lh = (atlas_h_log2_q < LOG2_LO) ? LOG2_LO :
			(atlas_h_log2_q > LOG2_HI) ? LOG2_HI : atlas_h_log2_q;
		aw = SW'(1) << lw;
		ah = SW'(1) << lh;

		x0   = first_s1 ? SW'(1) : SW'(cursor_x_q);
		y0   = first_s1 ? SW'(1) : SW'(cursor_y_q);
		row0 = first_s1 ? SW'(0) : SW'(shelf_h_q);
		ovf0 = first_s1 ? 1'b0 : overflow_q;

		w_ext = SW'(w_s1);
		h_ext = SW'(h_s1);
		h_pad = h_ext + SW'(sasa_pkg::PAD);

		brk  = (x0 + w_ext + SW'(sasa_pkg::PAD)) > aw;
		x1   = brk ? SW'(1) : x0;
		y1   = brk ? (y0 + row0) : y0;
		row1 = brk ? SW'(0) : row0;
		fit  = (y1 + h_pad) <= ah;

		zero_sz = (w_s1 == '0) || (h_s1 == '0);
		place   = !ovf0 && !zero_sz && fit;

		if (ovf0) begin
			st_c = sasa_pkg::ST_OVERFLOW;
		end else if (zero_sz) begin
			st_c = sasa_pkg::ST_SKIPPED;
		end else if (!fit) begin
			st_c = sasa_pkg::ST_OVERFLOW;
		end else begin
			st_c = sasa_pkg::ST_PLACED;
		end

		if (place) begin
			nx   = x1 + w_ext + SW'(sasa_pkg::PAD);
			ny   = y1;
			nrow = (h_pad > row1) ? h_pad : row1;
			novf = 1'b0;
		end else begin
			nx   = x0;
			ny   = y0;
			nrow = row0;
			novf = ovf0 || (!zero_sz && !fit);
		end
		packed_sum = ny + nrow;

		x_end = x1 + w_ext;
		y_end = y1 + h_ext;
		fx0   = {x1, {sasa_pkg::FRAC_W{1'b0}}} >> lw;
		fy0   = {y1, {sasa_pkg::FRAC_W{1'b0}}} >> lh;
		fx1   = {x_end, {sasa_pkg::FRAC_W{1'b0}}} >> lw;
		fy1   = {y_end, {sasa_pkg::FRAC_W{1'b0}}} >> lh;

		a_c = sasa_pkg::CHAN_MAX - color_s1[sasa_pkg::CHAN_W-1:0];
	end

	function automatic logic [sasa_pkg::FRAC_W-1:0] sat_frac(input logic [FW-1:0] f);
		begin
			sat_frac = (|f[FW-1:sasa_pkg::FRAC_W]) ? {sasa_pkg::FRAC_W{1'b1}} :
				f[sasa_pkg::FRAC_W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= PW'(1);
			cursor_y_q <= PW'(1);
			shelf_h_q  <= '0;
			overflow_q <= 1'b0;
			out_valid  <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				cursor_x_q <= nx[PW-1:0];
				cursor_y_q <= ny[PW-1:0];
				shelf_h_q  <= nrow[PW-1:0];
				overflow_q <= novf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status        <= st_c;
			packed_height <= packed_sum[sasa_pkg::PACKED_W-1:0];
			if (place) begin
				slot_x  <= x1[sasa_pkg::DIM_W-1:0];
				slot_y  <= y1[sasa_pkg::DIM_W-1:0];
				u_start <= sat_frac(fx0);
				v_start <= sat_frac(fy0);
				u_end   <= sat_frac(fx1);
				v_end   <= sat_frac(fy1);
				red     <= sasa_pkg::premul(color_s1[31:24], a_c);
				green   <= sasa_pkg::premul(color_s1[23:16], a_c);
				blue    <= sasa_pkg::premul(color_s1[15:8], a_c);
				alpha   <= a_c;
			end else begin
				slot_x  <= '0;
				slot_y  <= '0;
				u_start <= '0;
				v_start <= '0;
				u_end   <= '0;
				v_end   <= '0;
				red     <= '0;
				green   <= '0;
				blue    <= '0;
				alpha   <= '0;
			end
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while result register free");

	a_cursor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_x_q != '0) && (cursor_y_q != '0))
		else $error("shelf cursor reached zero");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == sasa_pkg::ST_PLACED || status == sasa_pkg::ST_SKIPPED ||
			status == sasa_pkg::ST_OVERFLOW))
		else $error("undefined status code");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(overflow_q) |-> $past(valid_s1 && first_s1 && advance))
		else $error("overflow cleared without frame start");

	a_placed_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sasa_pkg::ST_PLACED) |-> (slot_x != '0 && slot_y != '0))
		else $error("placed slot inside pad ring");

endmodule
